>>> hw/rtl/icpr_pkg.sv
// ----------------------------------------------------------------------------
// icpr_pkg
// Types and constants shared by the ICMP probe reply classifier modules.
// ----------------------------------------------------------------------------
package icpr_pkg;

	// packet limits
	localparam int unsigned MAX_PACKET_BYTES = 1500;
	localparam int unsigned POS_W = 11;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES);
	localparam int unsigned HLEN_W = 6;

	// protocol codes
	localparam logic [7:0] ICMP_DEST_UNREACH = 8'd3;
	localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] ICMP_CODE_TTL = 8'd0;
	localparam logic [7:0] UNREACH_PORT = 8'd3;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// verdict codes
	localparam logic [1:0] VERDICT_IGNORE = 2'd0;
	localparam logic [1:0] VERDICT_TIME_EXCEEDED = 2'd1;
	localparam logic [1:0] VERDICT_REACHED = 2'd2;
	localparam logic [1:0] VERDICT_UNREACH = 2'd3;

	// configuration register indexes
	localparam logic CFG_PROBE_SRC_PORT = 1'b0;
	localparam logic CFG_PROBE_DST_PORT = 1'b1;
	localparam logic [15:0] PROBE_SRC_PORT_RST = 16'h8000;
	localparam logic [15:0] PROBE_DST_PORT_RST = 16'h8001;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [7:0] icmp_code_seen;
		logic [31:0] responder_addr;
		logic new_hop;
	} out_item_t;

	// fields captured from one packet, handed from front to back
	typedef struct packed {
		logic [POS_W-1:0] len;
		logic [HLEN_W-1:0] outer_hlen;
		logic [HLEN_W-1:0] inner_hlen;
		logic [7:0] msg_type;
		logic [7:0] msg_code;
		logic [7:0] inner_proto;
		logic [15:0] udp_src;
		logic [15:0] udp_dst;
		logic [31:0] src_addr;
	} pkt_summary_t;

endpackage

>>> hw/rtl/icpr_front.sv
// ----------------------------------------------------------------------------
// icpr_front
// Byte parser: tracks the byte position, captures header fields and pushes a
// packet summary on the last byte.
// ----------------------------------------------------------------------------
module icpr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input icpr_pkg::in_item_t in_data,
	output logic push,
	input logic push_ready,
	output icpr_pkg::pkt_summary_t push_data
);
	import icpr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [HLEN_W-1:0] ol_q, il_q;
	logic [7:0] type_q, code_q, proto_q;
	logic [15:0] src_q, dst_q;
	logic [31:0] addr_q;

	logic [HLEN_W-1:0] ol_d, il_d;
	logic [7:0] type_d, code_d, proto_d;
	logic [15:0] src_d, dst_d;
	logic [31:0] addr_d;
	logic [POS_W-1:0] ol_x, il_x, len;
	logic [7:0] b;
	logic start, accept;

	assign in_ready = push_ready;
	assign accept = in_valid && in_ready;
	assign push = accept && in_data.last_byte;
	assign b = in_data.data_byte;
	assign start = (pos_q == '0);

	// field capture, header lengths take effect on the byte they arrive on
	always_comb begin
		ol_d = start ? '0 : ol_q;
		il_d = start ? '0 : il_q;
		type_d = start ? '0 : type_q;
		code_d = start ? '0 : code_q;
		proto_d = start ? '0 : proto_q;
		src_d = start ? '0 : src_q;
		dst_d = start ? '0 : dst_q;
		addr_d = start ? '0 : addr_q;
		ol_x = '0;
		il_x = '0;
		if (pos_q < POS_LIMIT) begin
			if (start)
				ol_d = {b[3:0], 2'b00};
			ol_x = POS_W'(ol_d);
			if (pos_q == ol_x)
				type_d = b;
			if (pos_q == ol_x + POS_W'(1))
				code_d = b;
			if (pos_q[POS_W-1:2] == (POS_W-2)'(3)) begin
				case (pos_q[1:0])
					2'd0: addr_d[31:24] = b;
					2'd1: addr_d[23:16] = b;
					2'd2: addr_d[15:8] = b;
					default: addr_d[7:0] = b;
				endcase
			end
			if (pos_q == ol_x + POS_W'(8))
				il_d = {b[3:0], 2'b00};
			il_x = POS_W'(il_d);
			if (pos_q == ol_x + POS_W'(17))
				proto_d = b;
			if (pos_q == ol_x + il_x + POS_W'(8))
				src_d[15:8] = b;
			if (pos_q == ol_x + il_x + POS_W'(9))
				src_d[7:0] = b;
			if (pos_q == ol_x + il_x + POS_W'(10))
				dst_d[15:8] = b;
			if (pos_q == ol_x + il_x + POS_W'(11))
				dst_d[7:0] = b;
		end
	end

	// packet length, limited to the maximum
	assign len = (pos_q >= POS_LIMIT) ? POS_LIMIT : pos_q + POS_W'(1);

	always_comb begin
		push_data.len = len;
		push_data.outer_hlen = ol_d;
		push_data.inner_hlen = il_d;
		push_data.msg_type = type_d;
		push_data.msg_code = code_d;
		push_data.inner_proto = proto_d;
		push_data.udp_src = src_d;
		push_data.udp_dst = dst_d;
		push_data.src_addr = addr_d;
	end

	// byte position counter, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (in_data.last_byte)
				pos_q <= '0;
			else if (pos_q != POS_MAX)
				pos_q <= pos_q + POS_W'(1);
		end
	end

	// capture registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ol_q <= '0;
			il_q <= '0;
			type_q <= '0;
			code_q <= '0;
			proto_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			addr_q <= '0;
		end else if (accept) begin
			ol_q <= ol_d;
			il_q <= il_d;
			type_q <= type_d;
			code_q <= code_d;
			proto_q <= proto_d;
			src_q <= src_d;
			dst_q <= dst_d;
			addr_q <= addr_d;
		end
	end

endmodule

>>> hw/rtl/icpr_queue.sv
// ----------------------------------------------------------------------------
// icpr_queue
// Two-entry queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
module icpr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic push_ready,
	input icpr_pkg::pkt_summary_t push_data,
	output logic head_valid,
	input logic pop,
	output icpr_pkg::pkt_summary_t head_data
);
	import icpr_pkg::*;

	pkt_summary_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

>>> hw/rtl/icpr_back.sv
// ----------------------------------------------------------------------------
// icpr_back
// Classifier: checks lengths, type and probe ports of a packet summary,
// tracks the last hop and holds the result item.
// ----------------------------------------------------------------------------
module icpr_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	output logic pop,
	input icpr_pkg::pkt_summary_t head_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output icpr_pkg::out_item_t out_data
);
	import icpr_pkg::*;

	logic [15:0] probe_src_q, probe_dst_q;
	logic [31:0] last_hop_q;
	logic last_hop_valid_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [POS_W-1:0] ol_x, il_x;
	logic type_ok, len_ok, match;
	logic [1:0] verdict;
	logic new_hop;

	assign cfg_ready = 1'b1;
	assign pop = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// verdict
	always_comb begin
		ol_x = POS_W'(head_data.outer_hlen);
		il_x = POS_W'(head_data.inner_hlen);
		type_ok = (head_data.msg_type == ICMP_TIME_EXCEEDED
			&& head_data.msg_code == ICMP_CODE_TTL)
			|| head_data.msg_type == ICMP_DEST_UNREACH;
		len_ok = (head_data.len >= ol_x + POS_W'(28))
			&& (head_data.len >= ol_x + il_x + POS_W'(12));
		match = head_data.inner_proto == PROTO_UDP
			&& head_data.udp_src == probe_src_q
			&& head_data.udp_dst == probe_dst_q;
		if (!(type_ok && len_ok && match))
			verdict = VERDICT_IGNORE;
		else if (head_data.msg_type == ICMP_TIME_EXCEEDED)
			verdict = VERDICT_TIME_EXCEEDED;
		else if (head_data.msg_code == UNREACH_PORT)
			verdict = VERDICT_REACHED;
		else
			verdict = VERDICT_UNREACH;
		new_hop = (verdict != VERDICT_IGNORE)
			&& (!last_hop_valid_q || last_hop_q != head_data.src_addr);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_src_q <= PROBE_SRC_PORT_RST;
			probe_dst_q <= PROBE_DST_PORT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PROBE_SRC_PORT: probe_src_q <= cfg_data;
				CFG_PROBE_DST_PORT: probe_dst_q <= cfg_data;
				default: probe_src_q <= probe_src_q;
			endcase
		end
	end

	// last hop tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hop_q <= '0;
			last_hop_valid_q <= 1'b0;
		end else if (pop && new_hop) begin
			last_hop_q <= head_data.src_addr;
			last_hop_valid_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.verdict <= verdict;
			out_q.icmp_code_seen <= head_data.msg_code;
			out_q.responder_addr <= head_data.src_addr;
			out_q.new_hop <= new_hop;
		end
	end

endmodule

>>> hw/rtl/icmp_probe_reply_classifier.sv
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Matches received ICMP replies against outstanding UDP probes, one packet
// byte per cycle while the summary queue has room, and reports a verdict per packet.
//
//   channel  direction  payload              accepted when
//   in       in         in_item_t            in_valid && in_ready
//   out      out        out_item_t           out_valid && out_ready
//   cfg      in         cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One byte is accepted per cycle while the summary queue is not full; the parser never holds a byte.
// A packet's summary is queued on its last byte, and its result is registered when popped from the queue.
// The two-entry summary queue stalls the input only when it is full.
// Reset clears position, captures, last hop and sets the probe ports.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input icpr_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output icpr_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	import icpr_pkg::*;

	logic push, push_ready, head_valid, pop;
	pkt_summary_t push_data, head_data;

	// byte parser
	icpr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push(push),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	// summary queue
	icpr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.push_data(push_data),
		.head_valid(head_valid),
		.pop(pop),
		.head_data(head_data)
	);

	// classifier and result register
	icpr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.pop(pop),
		.head_data(head_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives received IPv4 packets byte by byte into the ICMP probe reply
// classifier, tracks header offsets and captures in a local copy of the
// parser, and checks every verdict item field by field against it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import icpr_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block ports
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_PROBE_SRC_PORT;
	logic [15:0] cfg_data = '0;

	// idling percentages and receiver hold-off
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	logic out_hold = 1'b0;

	// local copy of the parser state and probe ports
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [POS_W-1:0] pos_q;
	logic [HLEN_W-1:0] outer_len_q;
	logic [HLEN_W-1:0] inner_len_q;
	logic [7:0] type_q;
	logic [7:0] code_q;
	logic [7:0] proto_q;
	logic [15:0] udp_src_q;
	logic [15:0] udp_dst_q;
	logic [31:0] addr_q;
	logic [31:0] hop_addr_q;
	logic hop_known_q;

	// verdicts still to arrive, oldest first
	out_item_t verdict_q[$];

	// packet under construction
	logic [7:0] pkt[$];
	logic [31:0] hop_pool[4];

	// tallies
	int n_fail = 0;
	int n_bytes = 0;
	int n_packets = 0;
	int n_new_hop = 0;
	int n_verdict[4] = '{0, 0, 0, 0};

	icmp_probe_reply_classifier i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// capture one byte and, on the last byte, queue the verdict it causes
	function automatic void classify_byte(input in_item_t it);
		int unsigned p, b, ol, il, plen;
		logic [1:0] v;
		logic nh;
		out_item_t r;
		p = pos_q;
		b = it.data_byte;
		// clear per-packet captures at packet start
		if (p == 0) begin
			outer_len_q = '0;
			inner_len_q = '0;
			type_q = '0;
			code_q = '0;
			proto_q = '0;
			udp_src_q = '0;
			udp_dst_q = '0;
			addr_q = '0;
		end
		// header lengths take effect on the byte that carries them
		if (p < MAX_PACKET_BYTES) begin
			if (p == 0)
				outer_len_q = HLEN_W'((b & 15) << 2);
			ol = outer_len_q;
			if (p == ol)
				type_q = 8'(b);
			if (p == ol + 1)
				code_q = 8'(b);
			if (p >= 12 && p < 16)
				addr_q = addr_q | (32'(b) << (8 * (15 - p)));
			if (p == ol + 8)
				inner_len_q = HLEN_W'((b & 15) << 2);
			il = inner_len_q;
			if (p == ol + 17)
				proto_q = 8'(b);
			if (p == ol + 8 + il)
				udp_src_q[15:8] = 8'(b);
			if (p == ol + 9 + il)
				udp_src_q[7:0] = 8'(b);
			if (p == ol + 10 + il)
				udp_dst_q[15:8] = 8'(b);
			if (p == ol + 11 + il)
				udp_dst_q[7:0] = 8'(b);
		end
		if (pos_q < POS_MAX)
			pos_q = pos_q + 1'b1;
		if (!it.last_byte)
			return;
		// length limits, type checks and probe match
		plen = (p + 1 > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : p + 1;
		ol = outer_len_q;
		il = inner_len_q;
		if (plen < ol + 8)
			v = VERDICT_IGNORE;
		else if (!((type_q == ICMP_TIME_EXCEEDED && code_q == ICMP_CODE_TTL) ||
				type_q == ICMP_DEST_UNREACH))
			v = VERDICT_IGNORE;
		else if (plen < ol + 28 || plen < ol + 12 + il)
			v = VERDICT_IGNORE;
		else if (!(proto_q == PROTO_UDP && udp_src_q == src_port_q &&
				udp_dst_q == dst_port_q))
			v = VERDICT_IGNORE;
		else if (type_q == ICMP_TIME_EXCEEDED)
			v = VERDICT_TIME_EXCEEDED;
		else if (code_q == UNREACH_PORT)
			v = VERDICT_REACHED;
		else
			v = VERDICT_UNREACH;
		// a matching reply from a different responder is a new hop
		nh = 1'b0;
		if (v != VERDICT_IGNORE && (!hop_known_q || hop_addr_q != addr_q)) begin
			nh = 1'b1;
			hop_addr_q = addr_q;
			hop_known_q = 1'b1;
		end
		r.verdict = v;
		r.icmp_code_seen = code_q;
		r.responder_addr = addr_q;
		r.new_hop = nh;
		verdict_q.push_back(r);
		n_verdict[v]++;
		if (nh)
			n_new_hop++;
		pos_q = '0;
	endfunction

	// report one field that differs
	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			n_fail++;
			if (n_fail <= 40)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, what, want, got);
		end
	endtask

	// receiver: check each accepted item, then choose next ready
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 40)
					$display("%0t ns: unexpected item, expected none, actual %0h",
						$time, out_data);
			end else begin
				want = verdict_q.pop_front();
				check_field("verdict", 32'(want.verdict), 32'(out_data.verdict));
				check_field("icmp_code_seen", 32'(want.icmp_code_seen),
					32'(out_data.icmp_code_seen));
				check_field("responder_addr", want.responder_addr,
					out_data.responder_addr);
				check_field("new_hop", 32'(want.new_hop), 32'(out_data.new_hop));
			end
		end
		if (out_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// offer one byte, idling at random first, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		in_item_t it;
		it.data_byte = b;
		it.last_byte = is_last;
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		classify_byte(it);
		n_bytes++;
	endtask

	// send the packet buffer, marking its final byte
	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		n_packets++;
	endtask

	// build a reply: outer header, icmp header, quoted ip and udp headers
	task automatic make_reply(input logic [3:0] oihl, input logic [3:0] iihl,
			input logic [7:0] typ, input logic [7:0] code, input logic [7:0] proto,
			input logic [15:0] sp, input logic [15:0] dp, input logic [31:0] addr,
			input int pad);
		int ol, il, n;
		ol = oihl * 4;
		il = iihl * 4;
		n = ol + 8 + ((il + 8 > 20) ? il + 8 : 20) + pad;
		pkt.delete();
		for (int i = 0; i < n; i++)
			pkt.push_back(8'($urandom));
		// later writes win where offsets overlap
		pkt[0] = {pkt[0][7:4], oihl};
		for (int k = 0; k < 4; k++)
			pkt[12 + k] = addr[31 - 8 * k -: 8];
		pkt[ol] = typ;
		pkt[ol + 1] = code;
		pkt[ol + 8] = {pkt[ol + 8][7:4], iihl};
		pkt[ol + 17] = proto;
		pkt[ol + 8 + il] = sp[15:8];
		pkt[ol + 9 + il] = sp[7:0];
		pkt[ol + 10 + il] = dp[15:8];
		pkt[ol + 11 + il] = dp[7:0];
	endtask

	// cut the packet buffer down to n bytes
	task automatic truncate(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	// random bytes, n of them
	task automatic make_noise(input int n);
		pkt.delete();
		for (int i = 0; i < n; i++)
			pkt.push_back(8'($urandom));
	endtask

	// drop valid, wait for every verdict, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write one probe port register while idle
	task automatic write_cfg(input logic idx, input logic [15:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PROBE_SRC_PORT)
			src_port_q = val;
		else
			dst_port_q = val;
	endtask

	// mostly well-formed probe reply with random content
	task automatic random_reply();
		logic [7:0] typ, code;
		typ = $urandom_range(0, 1) ? ICMP_TIME_EXCEEDED : ICMP_DEST_UNREACH;
		if (typ == ICMP_TIME_EXCEEDED)
			code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : ICMP_CODE_TTL;
		else
			code = $urandom_range(0, 1) ? UNREACH_PORT : 8'($urandom);
		make_reply(($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5,
			($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5,
			typ, code,
			($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP,
			($urandom_range(0, 9) == 0) ? 16'($urandom) : src_port_q,
			($urandom_range(0, 9) == 0) ? 16'($urandom) : dst_port_q,
			($urandom_range(0, 4) == 0) ? $urandom : hop_pool[$urandom_range(0, 3)],
			$urandom_range(0, 8));
	endtask

	// matching replies under the reset probe ports, hop zero first
	task automatic test_reset_ports();
		make_reply(5, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL, PROTO_UDP,
			PROBE_SRC_PORT_RST, PROBE_DST_PORT_RST, 32'h0, 0);
		send_packet();
		send_packet();
		make_noise(1);
		send_packet();
		wait_idle();
	endtask

	// every verdict kind and the ways a reply fails to match
	task automatic test_verdict_kinds();
		make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
			src_port_q, dst_port_q, 32'h0a000001, 0);
		send_packet();
		make_reply(5, 5, ICMP_DEST_UNREACH, 8'd0, PROTO_UDP,
			src_port_q, dst_port_q, 32'h0a000001, 2);
		send_packet();
		make_reply(6, 7, ICMP_DEST_UNREACH, 8'hff, PROTO_UDP,
			src_port_q, dst_port_q, 32'hc0a80101, 0);
		send_packet();
		// ignored reply leaves the stored hop alone
		make_reply(5, 5, ICMP_TIME_EXCEEDED, 8'd1, PROTO_UDP,
			src_port_q, dst_port_q, 32'hffffffff, 0);
		send_packet();
		make_reply(5, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL, PROTO_UDP,
			src_port_q, dst_port_q, 32'hc0a80101, 0);
		send_packet();
		make_reply(5, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL, 8'd6,
			src_port_q, dst_port_q, 32'h01020304, 0);
		send_packet();
		make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
			~src_port_q, dst_port_q, 32'h01020304, 0);
		send_packet();
		make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
			src_port_q, ~dst_port_q, 32'h01020304, 0);
		send_packet();
		make_reply(5, 5, 8'd0, 8'd0, PROTO_UDP, src_port_q, dst_port_q,
			32'h01020304, 0);
		send_packet();
		// all-zero and all-one packets
		make_noise(56);
		foreach (pkt[i]) pkt[i] = 8'h00;
		send_packet();
		make_noise(60);
		foreach (pkt[i]) pkt[i] = 8'hff;
		send_packet();
		wait_idle();
	endtask

	// each length limit just missed and just met
	task automatic test_short_packets();
		int cut[6];
		cut = '{27, 28, 47, 48, 91, 92};
		foreach (cut[i]) begin
			if (i < 4)
				make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
					src_port_q, dst_port_q, 32'h0a0a0a0a, 0);
			else
				make_reply(5, 15, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
					src_port_q, dst_port_q, 32'h0a0a0a0b, 0);
			truncate(cut[i]);
			send_packet();
		end
		make_reply(15, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL, PROTO_UDP,
			src_port_q, dst_port_q, 32'h0a0a0a0c, 0);
		truncate(67);
		send_packet();
		wait_idle();
	endtask

	// tiny header lengths put several fields on one byte
	task automatic test_overlapping_headers();
		for (int o = 0; o < 5; o++)
			for (int n = 0; n < 2; n++) begin
				make_reply(4'(o), 4'(n), ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
					src_port_q, dst_port_q, 32'h0b000000 | o, 4);
				send_packet();
			end
		wait_idle();
	endtask

	// probe ports at both extremes
	task automatic test_port_extremes();
		logic [15:0] ext[2];
		ext = '{16'h0000, 16'hffff};
		foreach (ext[i]) begin
			write_cfg(CFG_PROBE_SRC_PORT, ext[i]);
			write_cfg(CFG_PROBE_DST_PORT, ext[i]);
			make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
				ext[i], ext[i], 32'h0d000000 | i, 0);
			send_packet();
			make_reply(5, 5, ICMP_DEST_UNREACH, UNREACH_PORT, PROTO_UDP,
				~ext[i], ext[i], 32'h0d000010 | i, 0);
			send_packet();
		end
		wait_idle();
	endtask

	// receiver holds off while packets keep coming, filling the block
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		fork
			begin
				out_hold <= 1'b1;
				repeat (300) @(posedge clk);
				out_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 8; i++) begin
			if (i % 3 == 0)
				make_noise(1);
			else
				random_reply();
			send_packet();
		end
		wait_idle();
	endtask

	// one random phase with its own idling and probe ports
	task automatic random_phase(input int unsigned s_idle, input int unsigned r_idle,
			input logic [15:0] sp, input logic [15:0] dp);
		int b0, p0, r;
		write_cfg(CFG_PROBE_SRC_PORT, sp);
		write_cfg(CFG_PROBE_DST_PORT, dp);
		send_idle = s_idle;
		recv_idle = r_idle;
		foreach (hop_pool[i]) hop_pool[i] = $urandom;
		b0 = n_bytes;
		p0 = n_packets;
		while (n_bytes - b0 < 60 || n_packets - p0 < 2) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				random_reply();
			end else if (r < 75) begin
				random_reply();
				truncate($urandom_range(1, pkt.size()));
			end else if (r < 87) begin
				make_reply(4'($urandom), 4'($urandom),
					$urandom_range(0, 2) == 0 ? 8'($urandom) :
					($urandom_range(0, 1) ? ICMP_TIME_EXCEEDED : ICMP_DEST_UNREACH),
					8'($urandom), $urandom_range(0, 1) ? PROTO_UDP : 8'($urandom),
					$urandom_range(0, 1) ? src_port_q : 16'($urandom),
					$urandom_range(0, 1) ? dst_port_q : 16'($urandom),
					$urandom, $urandom_range(0, 6));
			end else begin
				make_noise($urandom_range(1, 48));
			end
			send_packet();
		end
		wait_idle();
	endtask

	task automatic test_random();
		random_phase(9, 60, 16'($urandom), 16'($urandom));
		random_phase(60, 9, 16'hffff, 16'h0000);
		random_phase(0, 0, 16'($urandom), 16'($urandom));
	endtask

	// main sequence
	initial begin
		src_port_q = PROBE_SRC_PORT_RST;
		dst_port_q = PROBE_DST_PORT_RST;
		pos_q = '0;
		outer_len_q = '0;
		inner_len_q = '0;
		type_q = '0;
		code_q = '0;
		proto_q = '0;
		udp_src_q = '0;
		udp_dst_q = '0;
		addr_q = '0;
		hop_addr_q = '0;
		hop_known_q = 1'b0;
		foreach (hop_pool[i]) hop_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 9;
		recv_idle = 60;
		test_reset_ports();
		test_verdict_kinds();
		test_short_packets();
		test_overlapping_headers();
		test_port_extremes();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (16) @(posedge clk);
		$display("covered %0d packets in %0d bytes, incl. short, overlapping and stalled",
			n_packets, n_bytes);
		$display("verdicts ignore %0d, time exceeded %0d, reached %0d, unreach %0d;",
			n_verdict[0], n_verdict[1], n_verdict[2], n_verdict[3]);
		$display("new hops %0d", n_new_hop);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("timeout with %0d verdicts outstanding", verdict_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> icmp_probe_reply_classifier.f
hw/rtl/icpr_pkg.sv
hw/rtl/icpr_front.sv
hw/rtl/icpr_queue.sv
hw/rtl/icpr_back.sv
hw/rtl/icmp_probe_reply_classifier.sv
test/testbench.sv
